// File: rtl/core/cpm_pkg.sv
// Package with the shared constants, types and state codes of the cyclic multiplier.
`timescale 1ns / 1ps

package cpm_pkg;

   // Ring size and derived widths.
   localparam int SIZE_N      = 64;
   localparam int IDX_W       = $clog2(SIZE_N);
   localparam int LC_W        = $clog2(SIZE_N + 1);
   localparam int COEF_W      = 16;
   localparam int COEF_IDX_W  = 6;
   localparam int PROD_W      = 2 * COEF_W;
   localparam int ACC_W       = PROD_W + IDX_W;
   localparam int RED_CNT_W   = $clog2(ACC_W);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [COEF_W-1:0] MOD_RESET = 16'd2048;

   // Kind of a queued word: a plain load or the load that starts a run.
   typedef enum logic {
      CMD_LOAD,
      CMD_RUN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic signed [COEF_W-1:0]  coef_a;
      logic signed [COEF_W-1:0]  coef_b;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_CAN_RD,
      BK_CAN_STA,
      BK_CAN_WA,
      BK_CAN_WB,
      BK_MAC,
      BK_DRAIN,
      BK_RED,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic             start;
      logic [ACC_W-1:0] value;
   } red_req_type;

   typedef struct packed {
      logic              done;
      logic [COEF_W-1:0] rem;
   } red_rsp_type;

endpackage

// File: rtl/core/cpm_if.sv
// Interfaces of the request, response and register-write channels.
`timescale 1ns / 1ps

interface cpm_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [cpm_pkg::COEF_W-1:0] coef_a;
   logic signed [cpm_pkg::COEF_W-1:0] coef_b;
   logic                              load_last;

   modport source (output valid, output coef_a, output coef_b, output load_last, input ready);
   modport sink   (input valid, input coef_a, input coef_b, input load_last, output ready);
endinterface

interface cpm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cpm_pkg::COEF_W-1:0]        product_coef;
   logic [cpm_pkg::COEF_IDX_W-1:0]    coef_index;
   logic                              result_last;

   modport source (output valid, output product_coef, output coef_index, output result_last,
                   input ready);
   modport sink   (input valid, input product_coef, input coef_index, input result_last,
                   output ready);
endinterface

interface cpm_csr_if;
   logic                       valid;
   logic                       ready;
   logic [cpm_pkg::COEF_W-1:0] modulus;

   modport source (output valid, output modulus, input ready);
   modport sink   (input valid, input modulus, output ready);
endinterface

// File: rtl/core/cpm_front.sv
// Front end: takes request words and register writes and classifies words for the queue.
`timescale 1ns / 1ps

module cpm_front (
   input  logic                          clock,
   input  logic                          reset,
   cpm_req_if.sink                       req,
   cpm_csr_if.sink                       csr,
   input  cpm_pkg::q_status_type         q_stat,
   output cpm_pkg::q_push_type           q_push,
   output logic [cpm_pkg::COEF_W-1:0]    modulus
);

   logic [cpm_pkg::COEF_W-1:0] modulus_ff;

   // The modulus register is always writable.
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= cpm_pkg::MOD_RESET;
      end else if (csr.valid) begin
         modulus_ff <= csr.modulus;
      end
   end

   assign modulus = modulus_ff;

   // A word is taken whenever the queue has room; the last pair becomes a run command.
   assign req.ready         = !q_stat.full;
   assign q_push.push       = req.valid && !q_stat.full;
   assign q_push.cmd.kind   = req.load_last ? cpm_pkg::CMD_RUN : cpm_pkg::CMD_LOAD;
   assign q_push.cmd.coef_a = req.coef_a;
   assign q_push.cmd.coef_b = req.coef_b;

endmodule

// File: rtl/core/cpm_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module cpm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  cpm_pkg::q_push_type   q_push,
   input  logic                  q_pop,
   output cpm_pkg::q_status_type q_stat,
   output cpm_pkg::cmd_type      q_head
);

   cpm_pkg::cmd_type              slot_ff [cpm_pkg::QUEUE_DEPTH];
   logic [cpm_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [cpm_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [cpm_pkg::QPTR_W:0]      count_ff;
   logic                          do_pop;

   assign do_pop = q_pop && (count_ff != '0);

   // Entry storage.
   always_ff @(posedge clock) begin
      if (q_push.push) begin
         slot_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (q_push.push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !q_push.push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign q_stat.full  = (count_ff == (cpm_pkg::QPTR_W + 1)'(cpm_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign q_head       = slot_ff[rd_ptr_ff];

endmodule

// File: rtl/core/cpm_reduce.sv
// Bit-serial remainder unit: reduces a wide sum modulo the modulus, one bit a cycle.
`timescale 1ns / 1ps

module cpm_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [cpm_pkg::COEF_W-1:0]  modulus,
   input  cpm_pkg::red_req_type        red_req,
   output cpm_pkg::red_rsp_type        red_rsp
);

   logic [cpm_pkg::ACC_W-1:0]     val_ff;
   logic [cpm_pkg::COEF_W-1:0]    rem_ff;
   logic [cpm_pkg::RED_CNT_W-1:0] cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [cpm_pkg::COEF_W:0]      trial;
   logic [cpm_pkg::COEF_W:0]      step_rem;

   // One restoring step: shift in the next bit and subtract the modulus if it fits.
   always_comb begin
      trial = {rem_ff, val_ff[cpm_pkg::ACC_W-1]};
      if (trial >= {1'b0, modulus}) begin
         step_rem = trial - {1'b0, modulus};
      end else begin
         step_rem = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (red_req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == cpm_pkg::RED_CNT_W'(cpm_pkg::ACC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (red_req.start && !busy_ff) begin
         val_ff <= red_req.value;
         rem_ff <= '0;
      end else if (busy_ff) begin
         val_ff <= {val_ff[cpm_pkg::ACC_W-2:0], 1'b0};
         rem_ff <= step_rem[cpm_pkg::COEF_W-1:0];
      end
   end

   assign red_rsp.done = done_ff;
   assign red_rsp.rem  = rem_ff;

endmodule

// File: rtl/core/cpm_back.sv
// Back end: coefficient stores, reduction of inputs, multiply-accumulate loop and result register.
`timescale 1ns / 1ps

module cpm_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cpm_pkg::cmd_type            q_head,
   input  cpm_pkg::q_status_type       q_stat,
   output logic                        q_pop,
   input  logic [cpm_pkg::COEF_W-1:0]  modulus,
   output cpm_pkg::red_req_type        red_req,
   input  cpm_pkg::red_rsp_type        red_rsp,
   cpm_rsp_if.source                   rsp
);

   localparam int IW = cpm_pkg::IDX_W;
   localparam int CW = cpm_pkg::COEF_W;
   localparam logic [IW-1:0] IDX_LAST = IW'(cpm_pkg::SIZE_N - 1);

   cpm_pkg::back_state_type state_ff, state_in;
   logic [cpm_pkg::LC_W-1:0]  lc_ff, lc_in;
   logic [IW-1:0]             ci_ff, ci_in;
   logic [IW-1:0]             k_ff, k_in;
   logic [IW-1:0]             mi_ff, mi_in;

   logic [CW-1:0] raw_a_mem [cpm_pkg::SIZE_N];
   logic [CW-1:0] raw_b_mem [cpm_pkg::SIZE_N];
   logic [CW-1:0] can_a_mem [cpm_pkg::SIZE_N];
   logic [CW-1:0] can_b_mem [cpm_pkg::SIZE_N];
   logic [CW-1:0] raw_a_q, raw_b_q, can_a_q, can_b_q;

   logic          raw_we, can_a_we, can_b_we, issue, acc_clr, rsp_load;
   logic [CW-1:0] canon_val;
   logic          cur_neg;
   logic [IW:0]   b_diff;
   logic [IW-1:0] b_addr;

   logic                          s1_v_ff, s2_v_ff;
   logic [cpm_pkg::PROD_W-1:0]    prod_ff;
   logic [cpm_pkg::ACC_W-1:0]     acc_ff;

   logic                            rsp_valid_ff;
   logic [CW-1:0]                   rsp_coef_ff;
   logic [cpm_pkg::COEF_IDX_W-1:0]  rsp_index_ff;
   logic                            rsp_last_ff;

   // Magnitude of a stored two's complement coefficient, as a reducer operand.
   function automatic logic [cpm_pkg::ACC_W-1:0] mag_of(input logic [CW-1:0] raw);
      logic [CW:0] m;
      begin
         if (raw[CW-1]) begin
            m = {1'b1, {CW{1'b0}}} - {1'b0, raw};
         end else begin
            m = {1'b0, raw};
         end
         mag_of = cpm_pkg::ACC_W'(m);
      end
   endfunction

   // Index of the B coefficient that pairs with A index mi for output k, modulo the ring size.
   always_comb begin
      b_diff = {1'b0, k_ff} - {1'b0, mi_ff};
      if (b_diff[IW]) begin
         b_addr = IW'(b_diff + (IW + 1)'(cpm_pkg::SIZE_N));
      end else begin
         b_addr = b_diff[IW-1:0];
      end
   end

   // A negative input maps to modulus minus its magnitude remainder.
   always_comb begin
      cur_neg = (state_ff == cpm_pkg::BK_CAN_WA) ? raw_a_q[CW-1] : raw_b_q[CW-1];
      if (cur_neg && red_rsp.rem != '0) begin
         canon_val = modulus - red_rsp.rem;
      end else begin
         canon_val = red_rsp.rem;
      end
   end

   // Coefficient stores with registered reads.
   always_ff @(posedge clock) begin
      if (raw_we) begin
         raw_a_mem[lc_ff[IW-1:0]] <= q_head.coef_a;
         raw_b_mem[lc_ff[IW-1:0]] <= q_head.coef_b;
      end
      raw_a_q <= raw_a_mem[ci_ff];
      raw_b_q <= raw_b_mem[ci_ff];
   end

   always_ff @(posedge clock) begin
      if (can_a_we) begin
         can_a_mem[ci_ff] <= canon_val;
      end
      if (can_b_we) begin
         can_b_mem[ci_ff] <= canon_val;
      end
      can_a_q <= can_a_mem[mi_ff];
      can_b_q <= can_b_mem[b_addr];
   end

   // Multiply-accumulate pipeline: read, multiply, accumulate.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= can_a_q * can_b_q;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (s2_v_ff) begin
         acc_ff <= acc_ff + cpm_pkg::ACC_W'(prod_ff);
      end
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpm_pkg::BK_IDLE;
         lc_ff    <= '0;
         ci_ff    <= '0;
         k_ff     <= '0;
         mi_ff    <= '0;
      end else begin
         state_ff <= state_in;
         lc_ff    <= lc_in;
         ci_ff    <= ci_in;
         k_ff     <= k_in;
         mi_ff    <= mi_in;
      end
   end

   // Next state and control.
   always_comb begin
      state_in      = state_ff;
      lc_in         = lc_ff;
      ci_in         = ci_ff;
      k_in          = k_ff;
      mi_in         = mi_ff;
      q_pop         = 1'b0;
      raw_we        = 1'b0;
      can_a_we      = 1'b0;
      can_b_we      = 1'b0;
      issue         = 1'b0;
      acc_clr       = 1'b0;
      rsp_load      = 1'b0;
      red_req.start = 1'b0;
      red_req.value = acc_ff;
      unique case (state_ff)
         cpm_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               if (lc_ff < cpm_pkg::LC_W'(cpm_pkg::SIZE_N)) begin
                  raw_we = 1'b1;
                  lc_in  = lc_ff + 1'b1;
               end
               if (q_head.kind == cpm_pkg::CMD_RUN) begin
                  lc_in    = '0;
                  ci_in    = '0;
                  state_in = cpm_pkg::BK_CAN_RD;
               end
            end
         end
         cpm_pkg::BK_CAN_RD: begin
            state_in = cpm_pkg::BK_CAN_STA;
         end
         cpm_pkg::BK_CAN_STA: begin
            red_req.start = 1'b1;
            red_req.value = mag_of(raw_a_q);
            state_in      = cpm_pkg::BK_CAN_WA;
         end
         cpm_pkg::BK_CAN_WA: begin
            if (red_rsp.done) begin
               can_a_we      = 1'b1;
               red_req.start = 1'b1;
               red_req.value = mag_of(raw_b_q);
               state_in      = cpm_pkg::BK_CAN_WB;
            end
         end
         cpm_pkg::BK_CAN_WB: begin
            if (red_rsp.done) begin
               can_b_we = 1'b1;
               if (ci_ff == IDX_LAST) begin
                  k_in     = '0;
                  mi_in    = '0;
                  acc_clr  = 1'b1;
                  state_in = cpm_pkg::BK_MAC;
               end else begin
                  ci_in    = ci_ff + 1'b1;
                  state_in = cpm_pkg::BK_CAN_RD;
               end
            end
         end
         cpm_pkg::BK_MAC: begin
            issue = 1'b1;
            if (mi_ff == IDX_LAST) begin
               mi_in    = '0;
               state_in = cpm_pkg::BK_DRAIN;
            end else begin
               mi_in = mi_ff + 1'b1;
            end
         end
         cpm_pkg::BK_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               red_req.start = 1'b1;
               state_in      = cpm_pkg::BK_RED;
            end
         end
         cpm_pkg::BK_RED: begin
            if (red_rsp.done) begin
               state_in = cpm_pkg::BK_OUT;
            end
         end
         cpm_pkg::BK_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               if (k_ff == IDX_LAST) begin
                  state_in = cpm_pkg::BK_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  mi_in    = '0;
                  acc_clr  = 1'b1;
                  state_in = cpm_pkg::BK_MAC;
               end
            end
         end
         default: begin
            state_in = cpm_pkg::BK_IDLE;
         end
      endcase
   end

   // Result register between the back end and the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_coef_ff  <= (modulus == '0) ? '0 : red_rsp.rem;
         rsp_index_ff <= cpm_pkg::COEF_IDX_W'(k_ff);
         rsp_last_ff  <= (k_ff == IDX_LAST);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.product_coef = rsp_coef_ff;
   assign rsp.coef_index   = rsp_index_ff;
   assign rsp.result_last  = rsp_last_ff;

endmodule

// File: rtl/core/cyclic_poly_mult_mod_q.sv
// Top level of the cyclic polynomial multiplier modulo a programmable modulus.
`timescale 1ns / 1ps

// Coefficient pairs are loaded one word per cycle, while the queue has room, through a
// four-entry queue; the word marked load_last starts a product in the ring of x^64 - 1
// modulo the modulus register, and 64 result words then come out in index order with
// the last one marked. Each of the 128 stored inputs is first reduced by the shared
// bit-serial remainder unit, then every output coefficient is summed in the single
// multiply-accumulate loop and reduced by the same remainder unit. Load words that
// queue up during a run are taken once the run has finished.
module cyclic_poly_mult_mod_q (
   input  logic       clock,
   input  logic       reset,
   cpm_req_if.sink    req,
   cpm_rsp_if.source  rsp,
   cpm_csr_if.sink    csr
);

   cpm_pkg::q_push_type        q_push;
   cpm_pkg::q_status_type      q_stat;
   cpm_pkg::cmd_type           q_head;
   logic                       q_pop;
   logic [cpm_pkg::COEF_W-1:0] modulus;
   cpm_pkg::red_req_type       red_req;
   cpm_pkg::red_rsp_type       red_rsp;

   cpm_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .csr     (csr),
      .q_stat  (q_stat),
      .q_push  (q_push),
      .modulus (modulus)
   );

   cpm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_stat (q_stat),
      .q_head (q_head)
   );

   cpm_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus),
      .red_req (red_req),
      .red_rsp (red_rsp)
   );

   cpm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_stat  (q_stat),
      .q_pop   (q_pop),
      .modulus (modulus),
      .red_req (red_req),
      .red_rsp (red_rsp),
      .rsp     (rsp)
   );

   // Every result must already be reduced below the modulus when the modulus exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (modulus > 16'd1) |-> rsp.product_coef < modulus)
      else $error("result coefficient not reduced below modulus");

   // The marked word is always the highest power of x.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_last |-> rsp.coef_index == cpm_pkg::COEF_IDX_W'(cpm_pkg::SIZE_N - 1))
      else $error("last result word carries the wrong index");

   // The front end never writes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !q_stat.full)
      else $error("queue overflow");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the cyclic polynomial multiplier modulo a programmable modulus.
`timescale 1ns / 1ps

module tb_top;

   // One coefficient pair as it is loaded.
   typedef struct {
      logic [cpm_pkg::COEF_W-1:0] coef_a;
      logic [cpm_pkg::COEF_W-1:0] coef_b;
      logic                       load_last;
   } coef_pair_type;

   // One product coefficient as it should come out.
   typedef struct {
      logic [cpm_pkg::COEF_W-1:0]     product_coef;
      logic [cpm_pkg::COEF_IDX_W-1:0] coef_index;
      logic                           result_last;
   } product_word_type;

   logic clock;
   logic reset;

   cpm_req_if req ();
   cpm_rsp_if rsp ();
   cpm_csr_if csr ();

   cyclic_poly_mult_mod_q dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   // Mirror of the block: both stores, the fill pointer and the modulus.
   logic [cpm_pkg::COEF_W-1:0] ring_a [cpm_pkg::SIZE_N];
   logic [cpm_pkg::COEF_W-1:0] ring_b [cpm_pkg::SIZE_N];
   int unsigned                fill_count;
   logic [cpm_pkg::COEF_W-1:0] modulus_reg;

   coef_pair_type    pending_pairs [$];
   product_word_type expected_coefs [$];
   coef_pair_type    cur_pair;
   bit               holding;
   int               gap_left;
   int               stall_left;
   bit               quiet_phase;
   int               errors;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Reduce a two's complement coefficient to 0 .. m-1.
   function automatic longint unsigned canon_coef(logic [cpm_pkg::COEF_W-1:0] raw,
                                                  longint unsigned m);
      longint unsigned r;
      if (raw[cpm_pkg::COEF_W-1]) begin
         r = (longint'(65536) - longint'(raw)) % m;
         return (r == 0) ? 0 : m - r;
      end
      return longint'(raw) % m;
   endfunction

   // Store one accepted pair; on the last one compute the whole cyclic product.
   function automatic void fold_pair(coef_pair_type p);
      longint unsigned  m;
      longint unsigned  acc [cpm_pkg::SIZE_N];
      longint unsigned  av;
      product_word_type w;
      m = modulus_reg;
      if (fill_count < cpm_pkg::SIZE_N) begin
         ring_a[fill_count] = p.coef_a;
         ring_b[fill_count] = p.coef_b;
         fill_count++;
      end
      if (!p.load_last) return;
      for (int k = 0; k < cpm_pkg::SIZE_N; k++) acc[k] = 0;
      if (m != 0) begin
         for (int i = 0; i < cpm_pkg::SIZE_N; i++) begin
            av = canon_coef(ring_a[i], m);
            for (int j = 0; j < cpm_pkg::SIZE_N; j++) begin
               acc[(i + j) % cpm_pkg::SIZE_N] = (acc[(i + j) % cpm_pkg::SIZE_N]
                                        + (av * canon_coef(ring_b[j], m)) % m) % m;
            end
         end
      end
      for (int k = 0; k < cpm_pkg::SIZE_N; k++) begin
         w.product_coef = acc[k][cpm_pkg::COEF_W-1:0];
         w.coef_index   = k[cpm_pkg::COEF_IDX_W-1:0];
         w.result_last  = (k == cpm_pkg::SIZE_N - 1);
         expected_coefs.push_back(w);
      end
      fill_count = 0;
   endfunction

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Coefficient with a bias toward the edges of the 16-bit range.
   function automatic logic [cpm_pkg::COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Queue one multiplication run of n pairs, the last one marked.
   task automatic queue_run(int n);
      coef_pair_type p;
      for (int i = 0; i < n; i++) begin
         p.coef_a    = pick_coef();
         p.coef_b    = pick_coef();
         p.load_last = (i == n - 1);
         pending_pairs.push_back(p);
      end
   endtask

   // Wait until every word is sent and every product word has arrived.
   task automatic wait_idle();
      while (pending_pairs.size() != 0 || holding || expected_coefs.size() != 0)
         @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   // Write the modulus register while the block is idle.
   task automatic write_modulus(logic [cpm_pkg::COEF_W-1:0] value);
      csr.valid   <= 1'b1;
      csr.modulus <= value;
      do @(posedge clock); while (!csr.ready);
      modulus_reg = value;
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic phase(logic [cpm_pkg::COEF_W-1:0] value, int n);
      wait_idle();
      write_modulus(value);
      quiet_phase = ($urandom_range(0, 3) == 0);
      queue_run(n);
   endtask

   // Driver: holds a word until it is taken, then waits out a random gap.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         holding   = 1'b0;
         gap_left  = 0;
      end else begin
         if (req.valid && req.ready) begin
            fold_pair(cur_pair);
            holding  = 1'b0;
            gap_left = pick_gap();
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_pairs.size() != 0) begin
               cur_pair = pending_pairs.pop_front();
               holding  = 1'b1;
            end
         end
         req.valid     <= holding;
         req.coef_a    <= cur_pair.coef_a;
         req.coef_b    <= cur_pair.coef_b;
         req.load_last <= cur_pair.load_last;
      end
   end

   // Monitor: stalls at random and checks each word against the oldest expected one.
   always @(posedge clock) begin
      product_word_type w;
      if (reset) begin
         rsp.ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_coefs.size() == 0) begin
               $display("%0t: unexpected word: product_coef %0d coef_index %0d last %0b",
                        $time, rsp.product_coef, rsp.coef_index, rsp.result_last);
               errors++;
            end else begin
               w = expected_coefs.pop_front();
               if (rsp.product_coef !== w.product_coef) begin
                  $display("%0t: product_coef expected %0d actual %0d", $time,
                           w.product_coef, rsp.product_coef);
                  errors++;
               end
               if (rsp.coef_index !== w.coef_index) begin
                  $display("%0t: coef_index expected %0d actual %0d", $time,
                           w.coef_index, rsp.coef_index);
                  errors++;
               end
               if (rsp.result_last !== w.result_last) begin
                  $display("%0t: result_last expected %0b actual %0b", $time,
                           w.result_last, rsp.result_last);
                  errors++;
               end
            end
         end
         if (stall_left > 0) stall_left--;
         else stall_left = pick_gap();
         rsp.ready <= (stall_left == 0);
      end
   end

   // Stimulus and end of test.
   initial begin
      int n;
      errors        = 0;
      fill_count    = 0;
      modulus_reg   = cpm_pkg::MOD_RESET;
      quiet_phase   = 1'b0;
      holding       = 1'b0;
      reset         = 1'b1;
      req.valid     = 1'b0;
      req.coef_a    = '0;
      req.coef_b    = '0;
      req.load_last = 1'b0;
      rsp.ready     = 1'b0;
      csr.valid     = 1'b0;
      csr.modulus   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full load at the largest modulus so every store entry holds data; the extra
      // pairs are dropped, and the late final pair only starts the run.
      phase(16'hFFFF, cpm_pkg::SIZE_N + 3);
      // Short loads at the smallest modulus and the meaningless ones.
      phase(16'd2, 3);
      phase(16'd0, 1);
      phase(16'd1, 2);
      phase(16'd3, 1);

      // Random short runs, with a random modulus now and then.
      for (int r = 0; r < 10; r++) begin
         n = $urandom_range(1, 8);
         if ($urandom_range(0, 1))
            phase(16'($urandom_range(2, 65535)), n);
         else
            phase(($urandom_range(0, 1) ? 16'hFFFF : 16'd2), n);
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
rtl/core/cpm_pkg.sv
rtl/core/cpm_if.sv
rtl/core/cpm_front.sv
rtl/core/cpm_queue.sv
rtl/core/cpm_reduce.sv
rtl/core/cpm_back.sv
rtl/core/cyclic_poly_mult_mod_q.sv
sim/tb_top.sv
